// ===== rtl/handle_path_cache_round_robin_macros.svh =====
// assertion macros for the handle path cache
`ifndef HANDLE_PATH_CACHE_ROUND_ROBIN_MACROS_SVH
`define HANDLE_PATH_CACHE_ROUND_ROBIN_MACROS_SVH

`ifndef SYNTHESIS
`define HPC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define HPC_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define HPC_ASSERT_IMP(label, ante, cons, msg)
`define HPC_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

// ===== rtl/hpc_pkg.sv =====
// shared types, constants and payload helpers for the handle path cache
package hpc_pkg;

	localparam int ENTRIES      = 512;
	localparam int PAYLOAD_BITS = 32;
	localparam int IDX_W        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int KEY_W        = 96;
	localparam int WORD_W       = 32;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	typedef struct packed {
		logic [KEY_W-1:0]        key;
		logic [PAYLOAD_BITS-1:0] payload;
	} hpc_entry_t;

	typedef struct packed {
		logic             shift;
		logic             wr;
		logic [IDX_W-1:0] wr_idx;
	} hpc_ring_ctrl_t;

	function automatic logic [PAYLOAD_BITS-1:0] to_payload(input logic [WORD_W-1:0] w);
		logic [63:0] wide;
		wide = 64'(w);
		return wide[PAYLOAD_BITS-1:0];
	endfunction

	function automatic logic [WORD_W-1:0] from_payload(input logic [PAYLOAD_BITS-1:0] p);
		logic [63:0] wide;
		wide = 64'(p);
		return wide[WORD_W-1:0];
	endfunction

endpackage

// ===== rtl/hpc_cell.sv =====
// one cache entry cell: loads from its neighbour when rotating, or from the write port
module hpc_cell import hpc_pkg::*; (
	input  logic       clk,
	input  logic       shift_en,
	input  logic       wr_en,
	input  hpc_entry_t shift_in,
	input  hpc_entry_t wr_data,
	output hpc_entry_t entry_q
);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q <= wr_data;
		end else if (shift_en) begin
			entry_q <= shift_in;
		end
	end

endmodule

// ===== rtl/hpc_ring.sv =====
// ring of entry cells with an indexed write decoder
module hpc_ring import hpc_pkg::*; (
	input  logic           clk,
	input  hpc_ring_ctrl_t ctrl,
	input  hpc_entry_t     wr_data,
	output hpc_entry_t     head
);

	hpc_entry_t cell_q [ENTRIES];

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		localparam int NEXT = (i + 1) % ENTRIES;
		logic wr_sel;

		assign wr_sel = ctrl.wr && (ctrl.wr_idx == IDX_W'(i));

		hpc_cell u_cell (
			.clk      (clk),
			.shift_en (ctrl.shift),
			.wr_en    (wr_sel),
			.shift_in (cell_q[NEXT]),
			.wr_data  (wr_data),
			.entry_q  (cell_q[i])
		);
	end

	assign head = cell_q[0];

endmodule

// ===== rtl/handle_path_cache_round_robin.sv =====
// handle path cache top level: request control, head compare and result register
//
// requests arrive on the s_ channel: s_tuser holds the operation (insert or lookup),
// s_tdata the 96-bit key and the payload word. results leave on the m_ channel:
// m_tuser is the hit flag, m_tdata the payload found by a lookup (zero otherwise).
// the entries sit in a ring of cells that rotates one place per cycle past a single
// key comparator, so one full rotation searches every entry and brings the ring back
// to its home position. an insert then writes the matching entry, or on a miss the
// slot under the round-robin pointer.
// after the search state a finish state loads the result register that drives
// m_tvalid; a new request is taken only once the finish state has passed.
// one request is in flight at a time; s_tready is high only while no search runs.
// the result register lets the next request start while a result waits; a stalled
// receiver holds the finished search until the register frees.
// reset empties the cache at once: entry validity follows the fill pointer and a
// wrap flag, so no clearing pass is needed.
`include "handle_path_cache_round_robin_macros.svh"

module handle_path_cache_round_robin import hpc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,  // export_key, device_key, inode_key, path_word
	input  logic [0:0]   s_tuser,  // opcode
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [31:0]  m_tdata,  // path_out
	output logic [0:0]   m_tuser   // hit
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SEARCH = 2'd1;
	localparam logic [1:0] ST_FINISH = 2'd2;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	logic [1:0]              state_q;
	logic [IDX_W-1:0]        cnt_q;
	logic [IDX_W-1:0]        ptr_q;
	logic                    full_q;
	logic                    op_q;
	logic [KEY_W-1:0]        key_q;
	logic [PAYLOAD_BITS-1:0] pay_q;
	logic                    found_q;
	logic [IDX_W-1:0]        found_idx_q;
	logic [PAYLOAD_BITS-1:0] found_pay_q;
	logic                    out_valid_q;
	logic                    hit_q;
	logic [WORD_W-1:0]       path_q;

	hpc_ring_ctrl_t ring_ctrl;
	hpc_entry_t     head;
	hpc_entry_t     wr_data;
	logic           s_fire;
	logic           head_valid;
	logic           head_match;
	logic           out_free;
	logic           finish_go;

	assign s_tready   = (state_q == ST_IDLE);
	assign s_fire     = s_tvalid && s_tready;
	assign head_valid = full_q || (cnt_q < ptr_q);
	assign head_match = head_valid && (head.key == key_q);
	assign out_free   = !out_valid_q || m_tready;
	assign finish_go  = (state_q == ST_FINISH) && out_free;

	assign ring_ctrl.shift  = (state_q == ST_SEARCH);
	assign ring_ctrl.wr     = finish_go && (op_q == OP_INSERT);
	assign ring_ctrl.wr_idx = found_q ? found_idx_q : ptr_q;
	assign wr_data.key      = key_q;
	assign wr_data.payload  = pay_q;

	hpc_ring u_ring (
		.clk     (clk),
		.ctrl    (ring_ctrl),
		.wr_data (wr_data),
		.head    (head)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			ptr_q       <= '0;
			full_q      <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (finish_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						state_q <= ST_SEARCH;
						cnt_q   <= '0;
						found_q <= 1'b0;
					end
				end
				ST_SEARCH: begin
					if (head_match && !found_q) begin
						found_q <= 1'b1;
					end
					if (cnt_q == LAST_IDX) begin
						cnt_q   <= '0;
						state_q <= ST_FINISH;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if ((op_q == OP_INSERT) && !found_q) begin
							if (ptr_q == LAST_IDX) begin
								ptr_q  <= '0;
								full_q <= 1'b1;
							end else begin
								ptr_q <= ptr_q + 1'b1;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			op_q  <= s_tuser[0];
			key_q <= s_tdata[95:0];
			pay_q <= to_payload(s_tdata[127:96]);
		end
		if ((state_q == ST_SEARCH) && head_match && !found_q) begin
			found_idx_q <= cnt_q;
			found_pay_q <= head.payload;
		end
		if (finish_go) begin
			hit_q  <= found_q;
			path_q <= ((op_q == OP_LOOKUP) && found_q) ? from_payload(found_pay_q) : '0;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = path_q;
	assign m_tuser[0] = hit_q;

	`HPC_ASSERT_NXT(a_start_search, s_tvalid && s_tready, state_q == ST_SEARCH && cnt_q == '0, "search did not start from the head")
	`HPC_ASSERT_IMP(a_found_behind, state_q == ST_SEARCH && found_q, found_idx_q < cnt_q, "recorded match index is not behind the rotation")
	`HPC_ASSERT_IMP(a_result_source, $rose(m_tvalid), $past(state_q == ST_FINISH), "result appeared without a finished search")
	`HPC_ASSERT_IMP(a_miss_zero, m_tvalid && !m_tuser[0], m_tdata == '0, "miss carries a non-zero payload")

endmodule

// ===== verif/tb.sv =====
// testbench for the handle path cache: directed and random requests checked against a predictor
`timescale 1ns / 100ps

module tb import hpc_pkg::*; ();

	typedef struct packed {
		logic              hit;
		logic [WORD_W-1:0] path;
	} reply_t;

	logic         clk      = 1'b0;
	logic         arst_n   = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [127:0] s_tdata  = '0;  // export_key, device_key, inode_key, path_word
	logic [0:0]   s_tuser  = '0;  // opcode
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [31:0]  m_tdata;        // path_out
	logic [0:0]   m_tuser;        // hit

	logic              shadow_valid [ENTRIES];
	logic [KEY_W-1:0]  shadow_key [ENTRIES];
	logic [WORD_W-1:0] shadow_payload [ENTRIES];
	logic [IDX_W-1:0]  shadow_ptr = '0;

	reply_t           pending_replies [$];
	logic [KEY_W-1:0] stored_keys [$];
	int unsigned      mismatches   = 0;
	bit               no_idle      = 1'b0;
	bit               hold_request = 1'b0;

	handle_path_cache_round_robin uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	function automatic reply_t predict_cache_access(input logic op, input logic [KEY_W-1:0] key,
			input logic [WORD_W-1:0] word);
		reply_t r;
		int     slot;
		slot = -1;
		for (int i = 0; i < ENTRIES; i++) begin
			if (slot < 0 && shadow_valid[i] && shadow_key[i] == key)
				slot = i;
		end
		r.hit  = (slot >= 0);
		r.path = '0;
		if (op == OP_INSERT) begin
			if (slot >= 0) begin
				shadow_payload[slot] = word;
			end else begin
				shadow_valid[shadow_ptr]   = 1'b1;
				shadow_key[shadow_ptr]     = key;
				shadow_payload[shadow_ptr] = word;
				shadow_ptr = (shadow_ptr == ENTRIES - 1) ? '0 : shadow_ptr + 1'b1;
			end
		end else if (slot >= 0) begin
			r.path = shadow_payload[slot];
		end
		return r;
	endfunction

	function automatic logic [KEY_W-1:0] fresh_key();
		return {$urandom, $urandom, $urandom};
	endfunction

	// mostly recent keys, some old enough to have been replaced
	function automatic logic [KEY_W-1:0] pick_known_key();
		int unsigned span;
		if (stored_keys.size() == 0)
			return fresh_key();
		span = (stored_keys.size() > 700) ? 700 : stored_keys.size();
		return stored_keys[stored_keys.size() - 1 - $urandom_range(span - 1)];
	endfunction

	task automatic note_mismatch(input string what, input logic [31:0] want, input logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s: expected %h, got %h", $time, what, want, got);
	endtask

	// called at a falling edge, returns at the falling edge after the transaction
	task automatic send_request(input logic op, input logic [KEY_W-1:0] key,
			input logic [WORD_W-1:0] word);
		int unsigned gap;
		reply_t      want;
		gap = 0;
		if (!no_idle) begin
			while ($urandom_range(99) < 21)
				gap++;
			if ($urandom_range(99) < 4)
				gap += $urandom_range(600, 1);
		end
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {word, key};
		do @(posedge clk); while (!s_tready);
		want = predict_cache_access(op, key, word);
		pending_replies.push_back(want);
		if (op == OP_INSERT && !want.hit) begin
			stored_keys.push_back(key);
			if (stored_keys.size() > 4096)
				void'(stored_keys.pop_front());
		end
		@(negedge clk);
	endtask

	task automatic wait_for_replies();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending_replies.size() != 0);
	endtask

	task automatic send_random_request();
		logic [KEY_W-1:0] key;
		logic             op;
		int unsigned      roll;
		roll = $urandom_range(99);
		key  = pick_known_key();
		op   = OP_LOOKUP;
		if (roll < 20) begin
			op  = OP_INSERT;
			key = fresh_key();
		end else if (roll < 40) begin
			op = OP_INSERT;
		end else if (roll < 50) begin
			key[$urandom_range(KEY_W - 1)] ^= 1'b1;
		end else if (roll < 55) begin
			op = OP_INSERT;
			key[$urandom_range(KEY_W - 1)] ^= 1'b1;
		end else if (roll < 60) begin
			key = fresh_key();
		end
		send_request(op, key, $urandom);
	endtask

	task automatic test_directed();
		logic [KEY_W-1:0] ones;
		logic [KEY_W-1:0] stripes;
		ones    = '1;
		stripes = {32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555};
		send_request(OP_LOOKUP, '0, 32'hffff_ffff);
		send_request(OP_INSERT, '0, 32'h0000_0000);
		send_request(OP_INSERT, ones, 32'hffff_ffff);
		send_request(OP_LOOKUP, '0, 32'h0000_0000);
		send_request(OP_LOOKUP, ones, 32'h0000_0000);
		send_request(OP_INSERT, '0, 32'ha5a5_a5a5);
		send_request(OP_LOOKUP, '0, 32'hffff_ffff);
		send_request(OP_LOOKUP, {ones[95:32], 32'h0}, 32'h0);
		send_request(OP_LOOKUP, {ones[95:64], 32'h0, ones[31:0]}, 32'h0);
		send_request(OP_LOOKUP, {32'h0, ones[63:0]}, 32'h0);
		send_request(OP_INSERT, stripes, 32'h5a5a_5a5a);
		send_request(OP_LOOKUP, stripes, 32'ha5a5_a5a5);
		send_request(OP_LOOKUP, ~stripes, 32'h0);
		wait_for_replies();
	endtask

	// more distinct keys than entries, so the replacement pointer wraps
	task automatic test_fill_and_wrap();
		no_idle = 1'b1;
		repeat (ENTRIES + 18)
			send_request(OP_INSERT, fresh_key(), $urandom);
		send_request(OP_LOOKUP, '0, 32'h0);
		send_request(OP_LOOKUP, stored_keys[stored_keys.size() - 1], 32'h0);
		send_request(OP_LOOKUP, stored_keys[stored_keys.size() - ENTRIES + 5], 32'h0);
		send_request(OP_INSERT, stored_keys[stored_keys.size() - 1], 32'hdead_0001);
		send_request(OP_LOOKUP, stored_keys[stored_keys.size() - 1], 32'h0);
		no_idle = 1'b0;
		wait_for_replies();
	endtask

	task automatic test_result_backpressure();
		hold_request = 1'b1;
		repeat (12)
			send_random_request();
		wait_for_replies();
	endtask

	task automatic test_random_traffic(input int unsigned count);
		for (int unsigned n = 1; n <= count; n++) begin
			send_random_request();
			if (n % 150 == 0)
				wait_for_replies();
		end
		wait_for_replies();
	endtask

	initial begin : result_sink
		int unsigned hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = 3000;
			end
			if (hold_left != 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= no_idle || ($urandom_range(99) >= 21);
			end
		end
	end

	always @(posedge clk) begin : check_replies
		reply_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_replies.size() == 0) begin
				note_mismatch("unexpected transaction, path_out", 32'h0, m_tdata);
			end else begin
				want = pending_replies.pop_front();
				if (m_tuser[0] !== want.hit)
					note_mismatch("hit", {31'h0, want.hit}, {31'h0, m_tuser[0]});
				if (m_tdata !== want.path)
					note_mismatch("path_out", want.path, m_tdata);
			end
		end
	end

	initial begin
		foreach (shadow_valid[i])
			shadow_valid[i] = 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_fill_and_wrap();
		test_result_backpressure();
		test_random_traffic(590);
		repeat (ENTRIES + 100) @(negedge clk);
		if (mismatches == 0 && pending_replies.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
